>>> rtl/bcrush_pkg.sv
// bcrush_pkg: shared types, constants and arithmetic helpers for the bitcrusher
// used by bitcrusher_with_filters_and_mix and its bench, no dependencies
`timescale 1ns / 1ps

package bcrush_pkg;

  // sizes
  localparam int CHANNELS          = 8;
  localparam int FILTERED_CHANNELS = 2;
  localparam int SAMPLE_BITS       = 16;
  localparam int DELAY_BITS        = SAMPLE_BITS + 8;
  localparam int CH_W              = 3;
  localparam int CH_AW             = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FILT_AW           = (FILTERED_CHANNELS > 1) ? $clog2(FILTERED_CHANNELS) : 1;
  localparam int HOLD_W            = 8;
  localparam int COEF_W            = 20;
  localparam int COEF_FRAC         = 18;
  localparam int MIX_W             = 13;
  localparam int MUL_A_W           = 25;
  localparam int MUL_B_W           = 26;
  localparam int PROD_W            = MUL_A_W + MUL_B_W;
  localparam int ACC_W             = PROD_W + 1;
  localparam int CFG_W             = 60;
  localparam int CFG_IDX_W         = 3;

  // channel store entry and filter store entry widths
  localparam int CH_MEM_W   = HOLD_W + SAMPLE_BITS;
  localparam int FILT_MEM_W = 4 * DELAY_BITS;

  // register fields
  localparam int SCALE_W = 25;
  localparam int STEP_W  = 24;
  localparam int FB_W    = 40;

  localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(4096);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HP_FORWARD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HP_FEEDBACK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LP_FORWARD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LP_FEEDBACK = 3'd7;

  // register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(16777216);
  localparam logic [STEP_W-1:0]  STEP_RST   = STEP_W'(256);
  localparam logic [HOLD_W-1:0]  PERIOD_RST = HOLD_W'(1);
  localparam logic [CFG_W-1:0]   FWD_RST    = CFG_W'(262144);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [CH_W-1:0]               channel_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [CH_W-1:0]               channel_out;
  } out_item_t;

  // round half away from zero, then arithmetic shift right
  function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
                                                        input int unsigned sh);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] half;
    logic [ACC_W-1:0] r;
    half = ACC_W'(1) << (sh - 1);
    mag  = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    r    = (mag + half) >> sh;
    return v[ACC_W-1] ? signed'(-r) : signed'(r);
  endfunction

  // saturate to the sample width
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = signed'((ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1));
    lo = -hi - ACC_W'(1);
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

  // saturate to the filter delay width
  function automatic logic signed [DELAY_BITS-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = signed'((ACC_W'(1) << (DELAY_BITS - 1)) - ACC_W'(1));
    lo = -hi - ACC_W'(1);
    if (v > hi) return hi[DELAY_BITS-1:0];
    if (v < lo) return lo[DELAY_BITS-1:0];
    return v[DELAY_BITS-1:0];
  endfunction

  // signed Q2.18 coefficient widened to the multiplier port
  function automatic logic signed [MUL_A_W-1:0] coef_ext(input logic [COEF_W-1:0] c);
    return MUL_A_W'(signed'(c));
  endfunction

endpackage

>>> rtl/bitcrusher_with_filters_and_mix.sv
// bitcrusher_with_filters_and_mix: sample-and-hold quantizer, biquads, dry/wet mix
// depends on bcrush_pkg and bcrush_ram
`timescale 1ns / 1ps
//
//  channel  | signals                        | direction
//  ---------+--------------------------------+----------
//  input    | in_valid, in_stall, in_data    | in
//  output   | out_valid, out_stall, out_data | out
//  config   | cfg_write, cfg_index, cfg_data | in
//
// One item at a time: the mix steps when the channel holds, the quantizer steps first when it
// captures, plus on filtered channels two biquads of 7 steps on the single shared multiplier.
// Per-channel state lives in two RAMs with registered reads; valid bits make
// unwritten entries read as zero after reset, so there is no clearing pass.
// A stalled output holds the sequencer in its final step; input is stalled until then.

module bitcrusher_with_filters_and_mix (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  bcrush_pkg::in_item_t                    in_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output bcrush_pkg::out_item_t                   out_data,
  input  logic                                    cfg_write,
  input  logic [bcrush_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bcrush_pkg::CFG_W-1:0]            cfg_data
);

  localparam int SW = bcrush_pkg::SAMPLE_BITS;
  localparam int DW = bcrush_pkg::DELAY_BITS;
  localparam int AW = bcrush_pkg::ACC_W;

  // sequencer codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_READ = 5'd1;
  localparam logic [4:0] S_Q1   = 5'd2;
  localparam logic [4:0] S_Q2   = 5'd3;
  localparam logic [4:0] S_Q3   = 5'd4;
  localparam logic [4:0] S_Q4   = 5'd5;
  localparam logic [4:0] S_B0   = 5'd6;
  localparam logic [4:0] S_B1   = 5'd7;
  localparam logic [4:0] S_B2   = 5'd8;
  localparam logic [4:0] S_B3   = 5'd9;
  localparam logic [4:0] S_B4   = 5'd10;
  localparam logic [4:0] S_B5   = 5'd11;
  localparam logic [4:0] S_B6   = 5'd12;
  localparam logic [4:0] S_M0   = 5'd13;
  localparam logic [4:0] S_M1   = 5'd14;
  localparam logic [4:0] S_M2   = 5'd15;
  localparam logic [4:0] S_M3   = 5'd16;

  // configuration registers
  logic [bcrush_pkg::SCALE_W-1:0] quant_scale;
  logic [bcrush_pkg::STEP_W-1:0]  quant_step;
  logic [bcrush_pkg::HOLD_W-1:0]  hold_period;
  logic [bcrush_pkg::MIX_W-1:0]   mix_level;
  logic [bcrush_pkg::CFG_W-1:0]   hp_forward;
  logic [bcrush_pkg::FB_W-1:0]    hp_feedback;
  logic [bcrush_pkg::CFG_W-1:0]   lp_forward;
  logic [bcrush_pkg::FB_W-1:0]    lp_feedback;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_scale <= bcrush_pkg::SCALE_RST;
      quant_step  <= bcrush_pkg::STEP_RST;
      hold_period <= bcrush_pkg::PERIOD_RST;
      mix_level   <= bcrush_pkg::MIX_ONE;
      hp_forward  <= bcrush_pkg::FWD_RST;
      hp_feedback <= '0;
      lp_forward  <= bcrush_pkg::FWD_RST;
      lp_feedback <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bcrush_pkg::REG_QUANT_SCALE: quant_scale <= cfg_data[bcrush_pkg::SCALE_W-1:0];
        bcrush_pkg::REG_QUANT_STEP:  quant_step  <= cfg_data[bcrush_pkg::STEP_W-1:0];
        bcrush_pkg::REG_HOLD_PERIOD: hold_period <= cfg_data[bcrush_pkg::HOLD_W-1:0];
        bcrush_pkg::REG_MIX_LEVEL:   mix_level   <= cfg_data[bcrush_pkg::MIX_W-1:0];
        bcrush_pkg::REG_HP_FORWARD:  hp_forward  <= cfg_data;
        bcrush_pkg::REG_HP_FEEDBACK: hp_feedback <= cfg_data[bcrush_pkg::FB_W-1:0];
        bcrush_pkg::REG_LP_FORWARD:  lp_forward  <= cfg_data;
        bcrush_pkg::REG_LP_FEEDBACK: lp_feedback <= cfg_data[bcrush_pkg::FB_W-1:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic [4:0]                           state;
  logic signed [SW-1:0]                 dry;
  logic [bcrush_pkg::CH_W-1:0]          chan;
  logic                                 bypass;
  logic                                 filtered;
  logic                                 lp_stage;
  logic [bcrush_pkg::HOLD_W-1:0]        hold_cnt;
  logic signed [SW-1:0]                 held;
  logic signed [bcrush_pkg::MUL_A_W-1:0] lv;
  logic signed [DW-1:0]                 x_reg;
  logic signed [DW-1:0]                 y_reg;
  logic signed [DW-1:0]                 hp_d1, hp_d2, lp_d1, lp_d2;
  logic signed [AW-1:0]                 acc, acc2;
  logic signed [bcrush_pkg::PROD_W-1:0] prod;
  logic signed [bcrush_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bcrush_pkg::MUL_B_W-1:0] mul_b;
  logic [bcrush_pkg::CHANNELS-1:0]          ch_vld;
  logic [bcrush_pkg::FILTERED_CHANNELS-1:0] filt_vld;

  // memory ports
  logic [bcrush_pkg::CH_AW-1:0]      ch_addr;
  logic [bcrush_pkg::FILT_AW-1:0]    filt_addr;
  logic [bcrush_pkg::CH_MEM_W-1:0]   ch_rdata;
  logic [bcrush_pkg::FILT_MEM_W-1:0] filt_rdata;
  logic                              mem_we;
  logic                              out_free;

  logic [bcrush_pkg::CH_W-1:0] ch_sel;
  logic [bcrush_pkg::MIX_W-1:0] mix_sat;
  logic signed [AW-1:0]          prod_ext;
  logic signed [AW-1:0]          d1_ext, d2_ext;
  logic [bcrush_pkg::CFG_W-1:0]  fwd_sel;
  logic [bcrush_pkg::FB_W-1:0]   fb_sel;
  logic                          read_hit;
  logic [bcrush_pkg::HOLD_W-1:0] rd_hold;
  logic signed [SW-1:0]          rd_held;
  logic [bcrush_pkg::FILT_MEM_W-1:0] rd_filt;
  logic signed [SW-1:0]          new_held;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign ch_sel   = (state == S_IDLE) ? in_data.channel_in : chan;
  assign ch_addr  = ch_sel[bcrush_pkg::CH_AW-1:0];
  assign filt_addr = ch_sel[bcrush_pkg::FILT_AW-1:0];
  assign mem_we   = (state == S_M3) && out_free && !bypass;
  assign mix_sat  = (mix_level > bcrush_pkg::MIX_ONE) ? bcrush_pkg::MIX_ONE : mix_level;
  assign prod_ext = AW'(prod);
  assign fwd_sel  = lp_stage ? lp_forward : hp_forward;
  assign fb_sel   = lp_stage ? lp_feedback : hp_feedback;
  assign d1_ext   = AW'(lp_stage ? lp_d1 : hp_d1) <<< bcrush_pkg::COEF_FRAC;
  assign d2_ext   = AW'(lp_stage ? lp_d2 : hp_d2) <<< bcrush_pkg::COEF_FRAC;

  // unwritten entries read as zero
  assign read_hit = ch_vld[chan[bcrush_pkg::CH_AW-1:0]];
  assign rd_hold  = read_hit ? ch_rdata[bcrush_pkg::CH_MEM_W-1:SW] : '0;
  assign rd_held  = read_hit ? signed'(ch_rdata[SW-1:0]) : '0;
  assign rd_filt  = filt_vld[chan[bcrush_pkg::FILT_AW-1:0]] ? filt_rdata : '0;
  assign new_held = bcrush_pkg::sat_sample(bcrush_pkg::rnd_shift(prod_ext, 25 - SW));

  bcrush_ram #(
    .WIDTH (bcrush_pkg::CH_MEM_W),
    .DEPTH (bcrush_pkg::CHANNELS)
  ) u_ch_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (chan[bcrush_pkg::CH_AW-1:0]),
    .wdata ({hold_cnt, held}),
    .raddr (ch_addr),
    .rdata (ch_rdata)
  );

  bcrush_ram #(
    .WIDTH (bcrush_pkg::FILT_MEM_W),
    .DEPTH (bcrush_pkg::FILTERED_CHANNELS)
  ) u_filt_ram (
    .clk   (clk),
    .we    (mem_we && filtered),
    .waddr (chan[bcrush_pkg::FILT_AW-1:0]),
    .wdata ({lp_d2, lp_d1, hp_d2, hp_d1}),
    .raddr (filt_addr),
    .rdata (filt_rdata)
  );

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_Q1: begin
        mul_a = bcrush_pkg::MUL_A_W'(dry);
        mul_b = signed'(bcrush_pkg::MUL_B_W'(quant_scale));
      end
      S_Q3: begin
        mul_a = lv;
        mul_b = signed'(bcrush_pkg::MUL_B_W'(quant_step));
      end
      S_B0: begin
        mul_a = bcrush_pkg::coef_ext(fwd_sel[19:0]);
        mul_b = bcrush_pkg::MUL_B_W'(x_reg);
      end
      S_B1: begin
        mul_a = bcrush_pkg::coef_ext(fwd_sel[39:20]);
        mul_b = bcrush_pkg::MUL_B_W'(x_reg);
      end
      S_B2: begin
        mul_a = bcrush_pkg::coef_ext(fwd_sel[59:40]);
        mul_b = bcrush_pkg::MUL_B_W'(x_reg);
      end
      S_B3: begin
        mul_a = bcrush_pkg::coef_ext(fb_sel[19:0]);
        mul_b = bcrush_pkg::MUL_B_W'(y_reg);
      end
      S_B4: begin
        mul_a = bcrush_pkg::coef_ext(fb_sel[39:20]);
        mul_b = bcrush_pkg::MUL_B_W'(y_reg);
      end
      S_M0: begin
        mul_a = bcrush_pkg::MUL_A_W'(dry);
        mul_b = signed'(bcrush_pkg::MUL_B_W'(bcrush_pkg::MIX_ONE - mix_sat));
      end
      S_M1: begin
        mul_a = bcrush_pkg::MUL_A_W'(x_reg);
        mul_b = signed'(bcrush_pkg::MUL_B_W'(mix_sat));
      end
      default: ;
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // valid bits for the state memories
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_vld   <= '0;
      filt_vld <= '0;
    end else if (mem_we) begin
      ch_vld[chan[bcrush_pkg::CH_AW-1:0]] <= 1'b1;
      if (filtered) begin
        filt_vld[chan[bcrush_pkg::FILT_AW-1:0]] <= 1'b1;
      end
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_valid) state <= S_READ;
        S_READ: begin
          if (bypass) state <= S_M3;
          else if (rd_hold == '0) state <= S_Q1;
          else if (filtered) state <= S_B0;
          else state <= S_M0;
        end
        S_Q1: state <= S_Q2;
        S_Q2: state <= S_Q3;
        S_Q3: state <= S_Q4;
        S_Q4: state <= filtered ? S_B0 : S_M0;
        S_B0: state <= S_B1;
        S_B1: state <= S_B2;
        S_B2: state <= S_B3;
        S_B3: state <= S_B4;
        S_B4: state <= S_B5;
        S_B5: state <= S_B6;
        S_B6: state <= lp_stage ? S_M0 : S_B0;
        S_M0: state <= S_M1;
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: begin
          if (out_free) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dry      <= in_data.sample_in;
        chan     <= in_data.channel_in;
        bypass   <= !(32'(in_data.channel_in) < bcrush_pkg::CHANNELS);
        filtered <= 32'(in_data.channel_in) < bcrush_pkg::FILTERED_CHANNELS;
        lp_stage <= 1'b0;
      end
      S_READ: begin
        held  <= rd_held;
        x_reg <= DW'(rd_held);
        hp_d1 <= signed'(rd_filt[DW-1:0]);
        hp_d2 <= signed'(rd_filt[2*DW-1:DW]);
        lp_d1 <= signed'(rd_filt[3*DW-1:2*DW]);
        lp_d2 <= signed'(rd_filt[4*DW-1:3*DW]);
        if (rd_hold == '0) begin
          hold_cnt <= (hold_period == '0) ? '0 : hold_period - 1'b1;
        end else begin
          hold_cnt <= rd_hold - 1'b1;
        end
      end
      S_Q2: lv <= bcrush_pkg::MUL_A_W'(bcrush_pkg::rnd_shift(prod_ext, SW + 7));
      S_Q4: begin
        held  <= new_held;
        x_reg <= DW'(new_held);
      end
      // y = b0*x + d1
      S_B1: acc <= prod_ext + d1_ext;
      S_B2: begin
        y_reg <= bcrush_pkg::sat_delay(bcrush_pkg::rnd_shift(acc, bcrush_pkg::COEF_FRAC));
        acc   <= prod_ext + d2_ext;
      end
      S_B3: acc2 <= prod_ext;
      S_B4: acc  <= acc - prod_ext;
      S_B5: begin
        acc2 <= acc2 - prod_ext;
        if (lp_stage) lp_d1 <= bcrush_pkg::sat_delay(bcrush_pkg::rnd_shift(acc, 18));
        else hp_d1 <= bcrush_pkg::sat_delay(bcrush_pkg::rnd_shift(acc, 18));
      end
      S_B6: begin
        if (lp_stage) lp_d2 <= bcrush_pkg::sat_delay(bcrush_pkg::rnd_shift(acc2, 18));
        else hp_d2 <= bcrush_pkg::sat_delay(bcrush_pkg::rnd_shift(acc2, 18));
        x_reg    <= y_reg;
        lp_stage <= 1'b1;
      end
      // dry and wet terms
      S_M1: acc <= prod_ext;
      S_M2: acc <= acc + prod_ext;
      S_M3: begin
        if (out_free) begin
          out_data.channel_out <= chan;
          out_data.sample_out  <= bypass ? dry
                                         : bcrush_pkg::sat_sample(bcrush_pkg::rnd_shift(acc, 12));
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/bcrush_ram.sv
// bcrush_ram: generic single write, single read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module bcrush_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> bench/bitcrusher_with_filters_and_mix_tb.sv
// bitcrusher_with_filters_and_mix_tb: self-checking bench for the bitcrusher with
// a bit-exact predictor, bursty sender, stalling receiver and register phases
// depends on bcrush_pkg and bitcrusher_with_filters_and_mix
`timescale 1ns / 1ps

module bitcrusher_with_filters_and_mix_tb;
  import bcrush_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bitcrusher_with_filters_and_mix dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [SCALE_W-1:0] m_scale;
  logic [STEP_W-1:0]  m_step;
  logic [HOLD_W-1:0]  m_period;
  logic [MIX_W-1:0]   m_mix;
  logic [CFG_W-1:0]   m_hp_fwd, m_lp_fwd;
  logic [FB_W-1:0]    m_hp_fb, m_lp_fb;

  // predictor copy of the per-channel state
  logic [HOLD_W-1:0] m_hold [CHANNELS];
  longint m_held [CHANNELS];
  longint m_hp_d1 [FILTERED_CHANNELS], m_hp_d2 [FILTERED_CHANNELS];
  longint m_lp_d1 [FILTERED_CHANNELS], m_lp_d2 [FILTERED_CHANNELS];

  in_item_t  pending_items [$];
  out_item_t crush_expect [$];
  bit offering = 0;
  int fail_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int squeeze_req = 0;

  // round half away from zero, then shift
  function automatic longint round_shift(longint v, int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint coef_at(logic [CFG_W-1:0] r, int k);
    logic signed [COEF_W-1:0] c;
    c = r[COEF_W*k +: COEF_W];
    return longint'(c);
  endfunction

  // transposed direct form II section
  function automatic longint biquad_step(logic [CFG_W-1:0] fwd, logic [CFG_W-1:0] fb,
                                         inout longint d1, inout longint d2, input longint x);
    longint y;
    y  = clamp(round_shift(coef_at(fwd, 0) * x + (d1 <<< COEF_FRAC), COEF_FRAC), DELAY_BITS);
    d1 = clamp(round_shift(coef_at(fwd, 1) * x - coef_at(fb, 0) * y + (d2 <<< COEF_FRAC),
                           COEF_FRAC), DELAY_BITS);
    d2 = clamp(round_shift(coef_at(fwd, 2) * x - coef_at(fb, 1) * y, COEF_FRAC), DELAY_BITS);
    return y;
  endfunction

  // expected output for one sample, advancing the predictor state
  function automatic out_item_t crush_predict(in_item_t it);
    out_item_t r;
    longint dry, lv, wet, mixv, d1, d2;
    int ch;
    dry = longint'(it.sample_in);
    ch = int'(it.channel_in);
    r.channel_out = it.channel_in;
    if (ch >= CHANNELS) begin
      r.sample_out = it.sample_in;
      return r;
    end
    if (m_hold[ch] == 0) begin
      lv = round_shift(dry * longint'(m_scale), SAMPLE_BITS + 7);
      m_held[ch] = clamp(round_shift(lv * longint'(m_step), 25 - SAMPLE_BITS), SAMPLE_BITS);
      m_hold[ch] = (m_period == '0) ? '0 : m_period - 1'b1;
    end else begin
      m_hold[ch] = m_hold[ch] - 1'b1;
    end
    wet = m_held[ch];
    if (ch < FILTERED_CHANNELS) begin
      d1 = m_hp_d1[ch]; d2 = m_hp_d2[ch];
      wet = biquad_step(m_hp_fwd, CFG_W'(m_hp_fb), d1, d2, wet);
      m_hp_d1[ch] = d1; m_hp_d2[ch] = d2;
      d1 = m_lp_d1[ch]; d2 = m_lp_d2[ch];
      wet = biquad_step(m_lp_fwd, CFG_W'(m_lp_fb), d1, d2, wet);
      m_lp_d1[ch] = d1; m_lp_d2[ch] = d2;
    end
    mixv = (m_mix > MIX_ONE) ? longint'(MIX_ONE) : longint'(m_mix);
    r.sample_out = SAMPLE_BITS'(clamp(round_shift(dry * (4096 - mixv) + wet * mixv, 12),
                                      SAMPLE_BITS));
    return r;
  endfunction

  // input side: accepted transfers feed the predictor
  always @(posedge clk) begin
    if (!rst && offering && in_valid && !in_stall) begin
      crush_expect.push_back(crush_predict(in_data));
      sent_count++;
      offering = 0;
    end
  end

  // driver: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!offering) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        offering = 1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: runs of stall and open, plus one long hold-off on request
  int run_left = 0;
  int squeeze_left = 0;
  bit stall_run = 0;
  always @(negedge clk) begin
    if (squeeze_req != 0) begin
      squeeze_left = squeeze_req;
      squeeze_req = 0;
    end
    if (squeeze_left > 0) begin
      squeeze_left--;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        stall_run = $urandom_range(0, 2) == 0;
        run_left = stall_run ? $urandom_range(1, 40) : $urandom_range(1, 60);
      end
      run_left--;
      out_stall <= stall_run;
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (crush_expect.size() == 0) begin
        $error("unexpected result: sample_out %0d channel_out %0d",
               out_data.sample_out, out_data.channel_out);
        fail_count++;
      end else begin
        want = crush_expect.pop_front();
        checked_count++;
        if (out_data.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, out_data.sample_out);
          fail_count++;
        end
        if (out_data.channel_out !== want.channel_out) begin
          $error("channel_out: expected %0d, got %0d", want.channel_out, out_data.channel_out);
          fail_count++;
        end
      end
    end
  end

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    case (idx)
      REG_QUANT_SCALE: m_scale = value[SCALE_W-1:0];
      REG_QUANT_STEP:  m_step = value[STEP_W-1:0];
      REG_HOLD_PERIOD: m_period = value[HOLD_W-1:0];
      REG_MIX_LEVEL:   m_mix = value[MIX_W-1:0];
      REG_HP_FORWARD:  m_hp_fwd = value[CFG_W-1:0];
      REG_HP_FEEDBACK: m_hp_fb = value[FB_W-1:0];
      REG_LP_FORWARD:  m_lp_fwd = value[CFG_W-1:0];
      default:         m_lp_fb = value[FB_W-1:0];
    endcase
  endtask

  task automatic writes_done();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || offering || crush_expect.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // value with random junk above the register width
  function automatic logic [63:0] junk_above(logic [63:0] v, int w);
    logic [63:0] j;
    j = {$urandom, $urandom};
    return (j & ~((64'd1 << w) - 1)) | v;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return COEF_W'($urandom_range(0, 65535));
      3: return -COEF_W'($urandom_range(0, 65535));
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_forward();
    return {4'($urandom), pick_coef(), pick_coef(), pick_coef()};
  endfunction

  function automatic logic [63:0] pick_feedback();
    return junk_above({pick_coef(), pick_coef()}, FB_W);
  endfunction

  task automatic random_items(int n);
    in_item_t it;
    repeat (n) begin
      it.sample_in = SAMPLE_BITS'($urandom);
      it.channel_in = ($urandom_range(0, 9) < 6) ? CH_W'($urandom_range(0, 1))
                                                  : CH_W'($urandom);
      pending_items.push_back(it);
    end
  endtask

  task automatic random_setup();
    reg_write(REG_QUANT_SCALE, junk_above($urandom_range(512, 16777216), SCALE_W));
    reg_write(REG_QUANT_STEP, junk_above($urandom_range(256, 8388608), STEP_W));
    reg_write(REG_HOLD_PERIOD, junk_above($urandom_range(0, 6) == 0 ? $urandom_range(0, 255)
                                                                  : $urandom_range(0, 5), HOLD_W));
    reg_write(REG_MIX_LEVEL, junk_above($urandom_range(0, 8191), MIX_W));
    reg_write(REG_HP_FORWARD, pick_forward());
    reg_write(REG_HP_FEEDBACK, pick_feedback());
    reg_write(REG_LP_FORWARD, pick_forward());
    reg_write(REG_LP_FEEDBACK, pick_feedback());
    writes_done();
  endtask

  // stimulus and register phases
  initial begin
    in_item_t it;
    m_scale = SCALE_RST; m_step = STEP_RST; m_period = PERIOD_RST; m_mix = MIX_ONE;
    m_hp_fwd = FWD_RST; m_lp_fwd = FWD_RST; m_hp_fb = '0; m_lp_fb = '0;
    foreach (m_hold[i]) begin
      m_hold[i] = '0;
      m_held[i] = 0;
    end
    foreach (m_hp_d1[i]) begin
      m_hp_d1[i] = 0; m_hp_d2[i] = 0; m_lp_d1[i] = 0; m_lp_d2[i] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes on every channel at reset settings
    for (int c = 0; c < CHANNELS; c++) begin
      it.channel_in = CH_W'(c);
      it.sample_in = (c % 2) ? 16'sh7FFF : 16'sh8000;
      pending_items.push_back(it);
      it.sample_in = (c < 4) ? 16'sh0000 : 16'shFFFF;
      pending_items.push_back(it);
    end
    wait_idle();

    // coarsest quantizer, zero hold period, mix above one, edge coefficients
    reg_write(REG_QUANT_SCALE, 512);
    reg_write(REG_QUANT_STEP, 8388608);
    reg_write(REG_HOLD_PERIOD, junk_above(0, HOLD_W));
    reg_write(REG_MIX_LEVEL, 8191);
    reg_write(REG_HP_FORWARD, {20'h80000, 20'h7FFFF, 20'h40000});
    reg_write(REG_HP_FEEDBACK, {20'h7FFFF, 20'h80000});
    reg_write(REG_LP_FORWARD, {20'h7FFFF, 20'h80000, 20'h7FFFF});
    reg_write(REG_LP_FEEDBACK, {20'h80000, 20'h7FFFF});
    writes_done();
    for (int b = 0; b < SAMPLE_BITS; b++) begin
      it.sample_in = 16'sd1 <<< b;
      it.channel_in = CH_W'(b % 3);
      pending_items.push_back(it);
    end
    wait_idle();

    // longest hold, fully dry
    reg_write(REG_HOLD_PERIOD, 255);
    reg_write(REG_MIX_LEVEL, 0);
    reg_write(REG_QUANT_SCALE, 16777216);
    reg_write(REG_QUANT_STEP, 256);
    writes_done();
    random_items(60);
    wait_idle();

    // random settings; one phase with a long receiver hold-off
    for (int p = 0; p < 5; p++) begin
      random_setup();
      if (p == 2) squeeze_req = 400;
      random_items(110);
      wait_idle();
    end

    $display("summary: %0d samples sent, %0d results checked over 8 register phases",
             sent_count, checked_count);
    $display("covered: quantizer and hold extremes, saturating filters, mix limits, stalls");
    if (fail_count == 0) begin
      $display("bitcrusher_with_filters_and_mix_tb passed");
    end else begin
      $display("bitcrusher_with_filters_and_mix_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("bitcrusher_with_filters_and_mix_tb failed");
    $finish;
  end

endmodule
